### design/dsef_pkg.sv
// shared types, codes and constants of the dle/stx/etx frame receiver
package dsef_pkg;

	// register index codes
	localparam logic [2:0] REG_MAX_LENGTH    = 3'd0;
	localparam logic [2:0] REG_FIRST_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_CHAR_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_ESCAPE_CODE   = 3'd3;
	localparam logic [2:0] REG_START_CODE    = 3'd4;
	localparam logic [2:0] REG_END_CODE      = 3'd5;

	// saturation value of the elapsed tick counter
	localparam logic [16:0] TICK_MAX = 17'h1FFFF;

	// input item kinds
	typedef enum logic [1:0] {
		MODE_BYTE = 2'd0,
		MODE_TICK = 2'd1,
		MODE_ARM  = 2'd2
	} mode_t;

	// result status codes
	typedef enum logic [2:0] {
		STS_NONE          = 3'd0,
		STS_PAYLOAD       = 3'd1,
		STS_DONE          = 3'd2,
		STS_RESTART       = 3'd3,
		STS_BAD_ESCAPE    = 3'd4,
		STS_FIRST_TIMEOUT = 3'd5,
		STS_CHAR_TIMEOUT  = 3'd6,
		STS_OVERFLOW      = 3'd7
	} status_t;

	// receiver states, one-hot
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_HUNT   = 5'b00010,
		S_START  = 5'b00100,
		S_DATA   = 5'b01000,
		S_ESCAPE = 5'b10000
	} rx_state_t;

	// configuration register set
	typedef struct packed {
		logic [15:0] max_length;
		logic [15:0] first_timeout;
		logic [15:0] char_timeout;
		logic [7:0]  escape_code;
		logic [7:0]  start_code;
		logic [7:0]  end_code;
	} cfg_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [7:0]  data;
		logic [15:0] pos;
	} res_t;

endpackage

### design/dsef_cfg_regs.sv
// configuration register file of the frame receiver
module dsef_cfg_regs
	import dsef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length    <= 16'd1024;
			cfg_q.first_timeout <= 16'd1000;
			cfg_q.char_timeout  <= 16'd100;
			cfg_q.escape_code   <= 8'd16;
			cfg_q.start_code    <= 8'd2;
			cfg_q.end_code      <= 8'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_LENGTH:    cfg_q.max_length    <= cfg_data;
				REG_FIRST_TIMEOUT: cfg_q.first_timeout <= cfg_data;
				REG_CHAR_TIMEOUT:  cfg_q.char_timeout  <= cfg_data;
				REG_ESCAPE_CODE:   cfg_q.escape_code   <= cfg_data[7:0];
				REG_START_CODE:    cfg_q.start_code    <= cfg_data[7:0];
				REG_END_CODE:      cfg_q.end_code      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/dsef_fsm.sv
// receiver state machine: destuffing, timeouts and length check
module dsef_fsm
	import dsef_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [1:0] mode,
	input  logic [7:0] byte_value,
	output res_t       res,
	output logic       armed
);

	rx_state_t   st_q, st_d;
	logic [15:0] cnt_q, cnt_d;
	logic        await_q, await_d;
	logic [16:0] el_q, el_d;
	logic [16:0] el_inc;
	logic        room;
	logic        is_esc, is_start, is_end;

	assign el_inc   = (el_q == TICK_MAX) ? el_q : el_q + 17'd1;
	assign room     = cnt_q < cfg.max_length;
	assign is_esc   = byte_value == cfg.escape_code;
	assign is_start = byte_value == cfg.start_code;
	assign is_end   = byte_value == cfg.end_code;
	assign armed    = st_q != S_IDLE;

	// next state and result for the item in the input register
	always_comb begin
		st_d       = st_q;
		cnt_d      = cnt_q;
		await_d    = await_q;
		el_d       = el_q;
		res.status = STS_NONE;
		res.data   = 8'd0;
		res.pos    = 16'd0;
		if (step) begin
			if (mode == MODE_ARM) begin
				st_d    = S_HUNT;
				cnt_d   = 16'd0;
				await_d = 1'b1;
				el_d    = 17'd0;
			end else if (mode == MODE_TICK && armed) begin
				el_d = el_inc;
				if (await_q) begin
					if (el_inc > {1'b0, cfg.first_timeout}) begin
						res.status = STS_FIRST_TIMEOUT;
						st_d       = S_IDLE;
					end
				end else if (el_inc > {1'b0, cfg.char_timeout}) begin
					res.status = STS_CHAR_TIMEOUT;
					st_d       = S_IDLE;
				end
			end else if (mode == MODE_BYTE && armed) begin
				await_d = 1'b0;
				el_d    = 17'd0;
				unique case (st_q)
					S_HUNT: begin
						if (is_esc)
							st_d = S_START;
					end
					S_START: begin
						st_d = is_start ? S_DATA : S_HUNT;
					end
					S_DATA, S_ESCAPE: begin
						if (st_q == S_DATA && is_esc) begin
							st_d = S_ESCAPE;
						end else if (st_q == S_DATA || is_esc) begin
							// payload byte, plain or destuffed escape
							if (room) begin
								res.status = STS_PAYLOAD;
								res.data   = byte_value;
								res.pos    = cnt_q;
								cnt_d      = cnt_q + 16'd1;
								st_d       = S_DATA;
							end else begin
								res.status = STS_OVERFLOW;
								st_d       = S_IDLE;
							end
						end else if (is_start) begin
							res.status = STS_RESTART;
							cnt_d      = 16'd0;
							st_d       = S_DATA;
						end else if (is_end) begin
							res.status = STS_DONE;
							res.pos    = cnt_q;
							st_d       = S_IDLE;
						end else begin
							res.status = STS_BAD_ESCAPE;
							cnt_d      = 16'd0;
							st_d       = S_HUNT;
						end
					end
					default: st_d = S_IDLE;
				endcase
			end
		end
	end

	// receiver state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			cnt_q   <= 16'd0;
			await_q <= 1'b1;
			el_q    <= 17'd0;
		end else begin
			st_q    <= st_d;
			cnt_q   <= cnt_d;
			await_q <= await_d;
			el_q    <= el_d;
		end
	end

endmodule

### design/dle_stx_etx_frame_receiver.sv
// top level of the dle/stx/etx frame receiver
//
// Input channel (in_valid, in_stall, mode, byte_value) carries one item per
// transfer: a line byte, a time tick or an arm command. Every item yields
// exactly one result on the output channel (out_valid, out_stall, status,
// data_byte, position); status 0 means nothing to report.
// An item lands in the input register at its transfer, and its result
// register loads from there as soon as the output side is free.
// Throughput: one item per cycle while out_stall stays low,
// sustained, since the per-item state update fits between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall rises only when both are occupied; one more item per
// cycle flows as soon as out_stall drops.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
// every cycle and should only be issued while no item is in flight.
// Reset returns the configuration registers to their defaults and leaves the
// receiver unarmed: bytes and ticks give status 0 until an arm item.
module dle_stx_etx_frame_receiver
	import dsef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  data_byte,
	output logic [15:0] position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       move_s1;
	logic       load_s1;
	logic       armed;

	assign cfg_ready = 1'b1;

	dsef_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline flow control
	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load_s1  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1 || move_s1)
			valid_s1 <= load_s1;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1 <= mode;
			byte_s1 <= byte_value;
		end
	end

	dsef_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (move_s1),
		.mode       (mode_s1),
		.byte_value (byte_s1),
		.res        (res),
		.armed      (armed)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (move_s1)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign data_byte = res_q.data;
	assign position  = res_q.pos;

	// an item leaving the input register always lands in the result register
	a_move_lands: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> out_valid)
		else $error("item lost between input and result register");

	// input side stalls only with a full input register
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled without a held item");

	// a terminal result leaves the receiver unarmed
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 && (res.status == STS_DONE || res.status == STS_OVERFLOW ||
		res.status == STS_FIRST_TIMEOUT || res.status == STS_CHAR_TIMEOUT)
		|=> !armed)
		else $error("receiver still armed after end of reception");

endmodule

### tb/dsef_frame_checker.sv
// checker for the frame receiver: tracks receiver state and compares every result
`timescale 1ns / 1ps
module dsef_frame_checker
	import dsef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [7:0]  data_byte,
	input  logic [15:0] position,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	// predicted register set and receiver state
	cfg_t        regs;
	rx_state_t   rx_phase;
	logic [16:0] byte_count;
	logic        first_pending;
	logic [16:0] tick_count;

	// results still owed by the block, oldest first
	res_t        owed_results[$];
	res_t        oldest;

	// store one payload byte, or report overflow once the length limit is hit
	function automatic res_t accept_payload(logic [7:0] b);
		res_t r;
		r = '0;
		if (byte_count < {1'b0, regs.max_length}) begin
			r.status = STS_PAYLOAD;
			r.data = b;
			r.pos = byte_count[15:0];
			byte_count = byte_count + 17'd1;
			rx_phase = S_DATA;
		end else begin
			r.status = STS_OVERFLOW;
			rx_phase = S_IDLE;
		end
		return r;
	endfunction

	// next receiver state and the one result caused by an item
	function automatic res_t frame_step(logic [1:0] m, logic [7:0] b);
		res_t r;
		r = '0;
		r.status = STS_NONE;
		// arm restarts hunting from any state
		if (m == MODE_ARM) begin
			rx_phase = S_HUNT;
			byte_count = '0;
			first_pending = 1'b1;
			tick_count = '0;
			return r;
		end
		if ((m != MODE_BYTE && m != MODE_TICK) || rx_phase == S_IDLE)
			return r;
		// ticks age the reception, saturating
		if (m == MODE_TICK) begin
			if (tick_count != TICK_MAX)
				tick_count = tick_count + 17'd1;
			if (first_pending) begin
				if (tick_count > {1'b0, regs.first_timeout}) begin
					r.status = STS_FIRST_TIMEOUT;
					rx_phase = S_IDLE;
				end
			end else if (tick_count > {1'b0, regs.char_timeout}) begin
				r.status = STS_CHAR_TIMEOUT;
				rx_phase = S_IDLE;
			end
			return r;
		end
		first_pending = 1'b0;
		tick_count = '0;
		case (rx_phase)
			S_HUNT: begin
				if (b == regs.escape_code)
					rx_phase = S_START;
			end
			S_START: begin
				rx_phase = (b == regs.start_code) ? S_DATA : S_HUNT;
			end
			S_DATA: begin
				if (b == regs.escape_code)
					rx_phase = S_ESCAPE;
				else
					r = accept_payload(b);
			end
			S_ESCAPE: begin
				// escape, start and end are tested in that order
				if (b == regs.escape_code) begin
					r = accept_payload(b);
				end else if (b == regs.start_code) begin
					byte_count = '0;
					rx_phase = S_DATA;
					r.status = STS_RESTART;
				end else if (b == regs.end_code) begin
					r.status = STS_DONE;
					r.pos = byte_count[15:0];
					rx_phase = S_IDLE;
				end else begin
					byte_count = '0;
					rx_phase = S_HUNT;
					r.status = STS_BAD_ESCAPE;
				end
			end
			default: begin
				rx_phase = S_IDLE;
			end
		endcase
		return r;
	endfunction

	// watch all three channels; results are checked before new items are queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.max_length = 16'd1024;
			regs.first_timeout = 16'd1000;
			regs.char_timeout = 16'd100;
			regs.escape_code = 8'h10;
			regs.start_code = 8'h02;
			regs.end_code = 8'h03;
			rx_phase = S_IDLE;
			byte_count = '0;
			first_pending = 1'b1;
			tick_count = '0;
			owed_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result transfer
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: status %0d data %02h position %0d",
							status, data_byte, position);
					fail_count = fail_count + 1;
				end else begin
					oldest = owed_results.pop_front();
					if (status !== oldest.status || data_byte !== oldest.data ||
						position !== oldest.pos) begin
						if (fail_count < 10)
							$display({"mismatch: expected status %0d data %02h ",
								"position %0d, got status %0d data %02h position %0d"},
								oldest.status, oldest.data, oldest.pos,
								status, data_byte, position);
						fail_count = fail_count + 1;
					end
				end
			end
			// register write transfer, unknown indexes are ignored
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_LENGTH:    regs.max_length = cfg_data;
					REG_FIRST_TIMEOUT: regs.first_timeout = cfg_data;
					REG_CHAR_TIMEOUT:  regs.char_timeout = cfg_data;
					REG_ESCAPE_CODE:   regs.escape_code = cfg_data[7:0];
					REG_START_CODE:    regs.start_code = cfg_data[7:0];
					REG_END_CODE:      regs.end_code = cfg_data[7:0];
					default: ;
				endcase
			end
			// item transfer
			if (in_valid && !in_stall)
				owed_results.push_back(frame_step(mode, byte_value));
			pending = owed_results.size();
		end
	end

endmodule

### tb/dle_stx_etx_frame_receiver_test.sv
// testbench top for the frame receiver: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module dle_stx_etx_frame_receiver_test
	import dsef_pkg::*;
();

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES = 7;
	localparam cfg_t RESET_REGS = '{
		max_length: 16'd1024, first_timeout: 16'd1000, char_timeout: 16'd100,
		escape_code: 8'h10, start_code: 8'h02, end_code: 8'h03};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  byte_value;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  data_byte;
	logic [15:0] position;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;

	int          cycle_count = 0;
	int          items_sent = 0;
	int          steady_left = 0;
	logic        hold_request = 1'b0;
	cfg_t        plan;

	always #4 clk = ~clk;

	dle_stx_etx_frame_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .byte_value(byte_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .data_byte(data_byte), .position(position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dsef_frame_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .byte_value(byte_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .data_byte(data_byte), .position(position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dle_stx_etx_frame_receiver verification failed");
			$finish;
		end
	end

	// receiver pacing: short and long stalls, calm stretches, one long hold-off on request
	initial begin : receiver_pacing
		int stall_left;
		int calm_left;
		int r;
		stall_left = 0;
		calm_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 300;
				calm_left = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (calm_left > 0) begin
				out_stall <= 1'b0;
				calm_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					calm_left = $urandom_range(20, 80);
				else if (r < 6)
					stall_left = $urandom_range(8, 40);
				else if (r < 30)
					stall_left = $urandom_range(1, 3);
				out_stall <= 1'b0;
			end
		end
	end

	// offer one item, hold it until the transfer, then maybe idle
	task automatic send_item(input logic [1:0] m, input logic [7:0] b);
		int r;
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		byte_value <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (steady_left > 0) begin
			steady_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 2)
				steady_left = $urandom_range(20, 60);
			if (r < 50)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 60);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(MODE_BYTE, b);
	endtask

	// a run of ticks that straddles the timeout when the threshold is small
	task automatic tick_run(input int thr);
		int n;
		n = (thr < 20) ? $urandom_range(0, thr + 2) : $urandom_range(0, 6);
		repeat (n) send_item(MODE_TICK, 8'($urandom));
	endtask

	// stop offering and wait until every owed result has come back
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write transfer; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// write the whole register set while idle, then an index past the list
	task automatic load_regs(input cfg_t c);
		wait_quiet();
		write_reg(REG_MAX_LENGTH, c.max_length);
		write_reg(REG_FIRST_TIMEOUT, c.first_timeout);
		write_reg(REG_CHAR_TIMEOUT, c.char_timeout);
		write_reg(REG_ESCAPE_CODE, {8'($urandom), c.escape_code});
		write_reg(REG_START_CODE, {8'($urandom), c.start_code});
		write_reg(REG_END_CODE, {8'($urandom), c.end_code});
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
		cfg_valid <= 1'b0;
		plan = c;
		repeat (2) @(posedge clk);
	endtask

	// small limits and timeouts, with colliding codes now and then
	function automatic cfg_t random_regs();
		cfg_t c;
		c.max_length = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
			: 16'($urandom_range(1, 12));
		c.first_timeout = 16'($urandom_range(0, 15));
		c.char_timeout = 16'($urandom_range(0, 10));
		c.escape_code = 8'($urandom);
		c.start_code = 8'($urandom);
		c.end_code = 8'($urandom);
		case ($urandom_range(0, 5))
			0: c.start_code = c.escape_code;
			1: c.end_code = c.escape_code;
			2: c.end_code = c.start_code;
			default: ;
		endcase
		return c;
	endfunction

	// one reception: mostly well-formed frames with random content, some broken
	task automatic random_frame();
		int r;
		int len;
		logic [7:0] b;
		send_item(MODE_ARM, 8'($urandom));
		if ($urandom_range(0, 9) == 0)
			tick_run(plan.first_timeout);
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
		// false start: escape followed by a random byte
		if ($urandom_range(0, 11) == 0) begin
			send_byte(plan.escape_code);
			send_byte(8'($urandom));
		end
		send_byte(plan.escape_code);
		send_byte(plan.start_code);
		len = $urandom_range(0, 12);
		if (plan.max_length <= 16 && $urandom_range(0, 3) == 0)
			len = plan.max_length + $urandom_range(0, 2);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				tick_run(plan.char_timeout);
			end else if (r < 11) begin
				send_item(MODE_UNUSED, 8'($urandom));
			end else if (r < 14) begin
				send_byte(plan.escape_code);
				send_byte(plan.start_code);
			end else if (r < 16) begin
				send_byte(plan.escape_code);
				send_byte(8'($urandom));
			end
			// data escape bytes are doubled
			b = ($urandom_range(0, 4) == 0) ? plan.escape_code : 8'($urandom);
			if (b == plan.escape_code)
				send_byte(b);
			send_byte(b);
		end
		r = $urandom_range(0, 99);
		if (r < 78) begin
			send_byte(plan.escape_code);
			send_byte(plan.end_code);
		end else if (r < 86) begin
			send_byte(plan.escape_code);
			send_byte(8'($urandom));
		end else if (r < 93) begin
			tick_run(plan.char_timeout);
		end
		if ($urandom_range(0, 9) == 0)
			send_byte(8'($urandom));
	endtask

	// main sequence
	initial begin : stimulus
		cfg_t c;
		int quota_end;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_BYTE;
		byte_value <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MAX_LENGTH;
		cfg_data <= 16'h0000;
		plan = RESET_REGS;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset codes: unarmed items, every receiver state, stuffing, restart, bad escape
		send_byte(8'h10);
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_ARM, 8'hFF);
		send_byte(8'h55);
		send_byte(8'h10);
		send_byte(8'h41);
		send_byte(8'h10);
		send_byte(8'h10);
		send_byte(8'h10);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h10);
		send_byte(8'h10);
		send_byte(8'h10);
		send_byte(8'h02);
		send_item(MODE_TICK, 8'hA5);
		send_item(MODE_UNUSED, 8'h5A);
		send_byte(8'h10);
		send_byte(8'h99);
		send_byte(8'h10);
		send_byte(8'h02);
		send_byte(8'hAA);
		send_byte(8'h10);
		send_byte(8'h03);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: c = RESET_REGS;
				1: c = '{16'h0000, 16'h0000, 16'h0000, 8'h00, 8'hFF, 8'h80};
				2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'hFF};
				NUM_PHASES - 1: c = RESET_REGS;
				default: c = random_regs();
			endcase
			if (p > 0)
				load_regs(c);
			if (p == 1) begin
				// zero timeouts and zero length limit
				send_item(MODE_ARM, 8'h00);
				send_item(MODE_TICK, 8'h00);
				send_item(MODE_TICK, 8'h00);
				send_item(MODE_ARM, 8'h00);
				send_byte(8'h00);
				send_item(MODE_TICK, 8'h00);
				send_item(MODE_ARM, 8'h00);
				send_byte(8'h00);
				send_byte(8'hFF);
				send_byte(8'h42);
			end
			// long receiver hold-off while frames keep coming
			if (p == 2)
				hold_request = 1'b1;
			quota_end = items_sent + ((p == 1) ? 110 : (p == 0 || p == NUM_PHASES - 1) ? 170 : 250);
			while (items_sent < quota_end)
				random_frame();
		end

		wait_quiet();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("dle_stx_etx_frame_receiver verification clean");
		else
			$display("dle_stx_etx_frame_receiver verification failed");
		$finish;
	end

endmodule
